[hdl/drp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package drp_pkg;

    localparam int VERSION_W = 5;
    localparam logic [VERSION_W-1:0] VERSION_RESET = 5'd1;
    localparam logic [3:0] HDR_LAST_BYTE = 4'd11;

    typedef enum logic [2:0] {
        KIND_HEADER      = 3'd0,
        KIND_FIELD       = 3'd1,
        KIND_DONE        = 3'd2,
        KIND_VERSION_ERR = 3'd3,
        KIND_INCOMPLETE  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        TAG_OPTIONS = 2'd0,
        TAG_ID      = 2'd1,
        TAG_TYPE    = 2'd2,
        TAG_DATA    = 2'd3
    } t_tag;

    typedef struct packed {
        t_kind       kind;
        t_tag        field_tag;
        logic [7:0]  byte_value;
        logic        end_of_field;
        logic        first_flag;
        logic        last_flag;
        logic        chunked_flag;
        logic [3:0]  type_format;
        logic [15:0] options_length;
        logic [15:0] id_length;
        logic [15:0] type_length;
        logic [31:0] data_length;
    } t_result;

    // one accepted byte yields at most two results; the second one never carries payload
    typedef struct packed {
        t_result first;
        logic    has_second;
        t_kind   second_kind;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

[hdl/drp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module drp_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_wr_en,
    input  wire  [4:0]              i_cfg_wr_data,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [7:0]              i_data_byte,
    input  wire                     i_end_of_buffer,
    input  drp_pkg::t_queue_status  i_q_stat,
    output logic                    o_push,
    output drp_pkg::t_entry         o_entry
);
    import drp_pkg::*;

    typedef enum logic [5:0] {
        ST_HDR  = 6'b000001,
        ST_OPT  = 6'b000010,
        ST_ID   = 6'b000100,
        ST_TYP  = 6'b001000,
        ST_DAT  = 6'b010000,
        ST_DROP = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [31:0]           r_cnt, n_cnt;
    logic [2:0]            r_flags, n_flags;
    logic [3:0]            r_tfmt, n_tfmt;
    logic [15:0]           r_opt, n_opt;
    logic [15:0]           r_id, n_id;
    logic [15:0]           r_typ, n_typ;
    logic [31:0]           r_dat, n_dat;
    logic [VERSION_W-1:0]  r_ver;

    logic        w_acc;
    t_tag        w_tag;
    logic [31:0] w_len;
    logic [31:0] w_lenm1;
    logic [3:0]  w_nz_reg;
    logic        w_early;
    t_entry      w_entry;

    function automatic t_state pick_field(input logic [3:0] nz, input logic [2:0] from);
        t_state s;
        if (nz[0] && from == 3'd0) begin
            s = ST_OPT;
        end else if (nz[1] && from <= 3'd1) begin
            s = ST_ID;
        end else if (nz[2] && from <= 3'd2) begin
            s = ST_TYP;
        end else if (nz[3] && from <= 3'd3) begin
            s = ST_DAT;
        end else begin
            s = ST_HDR;
        end
        return s;
    endfunction

    assign o_ready = !i_q_stat.full;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        case (r_state)
            ST_OPT:  w_tag = TAG_OPTIONS;
            ST_ID:   w_tag = TAG_ID;
            ST_TYP:  w_tag = TAG_TYPE;
            default: w_tag = TAG_DATA;
        endcase
        case (w_tag)
            TAG_OPTIONS: w_len = {16'd0, r_opt};
            TAG_ID:      w_len = {16'd0, r_id};
            TAG_TYPE:    w_len = {16'd0, r_typ};
            default:     w_len = r_dat;
        endcase
    end

    assign w_lenm1  = w_len - 32'd1;
    assign w_nz_reg = {r_dat != 32'd0, r_typ != 16'd0, r_id != 16'd0, r_opt != 16'd0};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_flags = r_flags;
        n_tfmt  = r_tfmt;
        n_opt   = r_opt;
        n_id    = r_id;
        n_typ   = r_typ;
        n_dat   = r_dat;
        w_early = 1'b0;
        w_entry = '0;
        o_push  = 1'b0;

        if (w_acc) begin
            case (r_state)
                ST_DROP: begin
                    w_early = 1'b1;
                    if (i_end_of_buffer) begin
                        n_state = ST_HDR;
                        n_cnt   = 32'd0;
                    end
                end
                ST_HDR: begin
                    if (r_cnt == 32'd0 && i_data_byte[7:3] != r_ver) begin
                        w_early          = 1'b1;
                        w_entry.first.kind = KIND_VERSION_ERR;
                        o_push           = 1'b1;
                        n_cnt            = 32'd0;
                        n_state          = i_end_of_buffer ? ST_HDR : ST_DROP;
                    end else begin
                        case (r_cnt[3:0])
                            4'd0:                    n_flags = i_data_byte[2:0];
                            4'd1:                    n_tfmt  = i_data_byte[7:4];
                            4'd2, 4'd3:              n_opt   = {r_opt[7:0], i_data_byte};
                            4'd4, 4'd5:              n_id    = {r_id[7:0], i_data_byte};
                            4'd6, 4'd7:              n_typ   = {r_typ[7:0], i_data_byte};
                            4'd8, 4'd9, 4'd10, 4'd11: n_dat  = {r_dat[23:0], i_data_byte};
                            default: ;
                        endcase
                        if (r_cnt[3:0] == HDR_LAST_BYTE) begin
                            o_push                        = 1'b1;
                            w_entry.first.kind            = KIND_HEADER;
                            w_entry.first.first_flag      = n_flags[2];
                            w_entry.first.last_flag       = n_flags[1];
                            w_entry.first.chunked_flag    = n_flags[0];
                            w_entry.first.type_format     = n_tfmt;
                            w_entry.first.options_length  = n_opt;
                            w_entry.first.id_length       = n_id;
                            w_entry.first.type_length     = n_typ;
                            w_entry.first.data_length     = n_dat;
                            n_cnt                         = 32'd0;
                            n_state = pick_field({n_dat != 32'd0, n_typ != 16'd0,
                                                  n_id != 16'd0, n_opt != 16'd0}, 3'd0);
                            if (n_state == ST_HDR) begin
                                w_entry.has_second  = 1'b1;
                                w_entry.second_kind = KIND_DONE;
                            end
                        end else begin
                            n_cnt = r_cnt + 32'd1;
                        end
                    end
                end
                ST_OPT, ST_ID, ST_TYP, ST_DAT: begin
                    if (r_cnt <= w_lenm1) begin
                        o_push                     = 1'b1;
                        w_entry.first.kind         = KIND_FIELD;
                        w_entry.first.field_tag    = w_tag;
                        w_entry.first.byte_value   = i_data_byte;
                        w_entry.first.end_of_field = (r_cnt == w_lenm1);
                    end
                    // last pad byte: counter reaches the length rounded up to four, minus one
                    if (r_cnt[31:2] == w_lenm1[31:2] && r_cnt[1:0] == 2'b11) begin
                        n_cnt   = 32'd0;
                        n_state = pick_field(w_nz_reg, {1'b0, w_tag} + 3'd1);
                        if (n_state == ST_HDR) begin
                            if (o_push) begin
                                w_entry.has_second  = 1'b1;
                                w_entry.second_kind = KIND_DONE;
                            end else begin
                                o_push             = 1'b1;
                                w_entry.first.kind = KIND_DONE;
                            end
                        end
                    end else begin
                        n_cnt = r_cnt + 32'd1;
                    end
                end
                default: begin
                    w_early = 1'b1;
                    n_state = ST_HDR;
                    n_cnt   = 32'd0;
                end
            endcase

            // buffer ended inside a record
            if (!w_early && i_end_of_buffer && (n_state != ST_HDR || n_cnt != 32'd0)) begin
                n_state = ST_HDR;
                n_cnt   = 32'd0;
                if (o_push) begin
                    w_entry.has_second  = 1'b1;
                    w_entry.second_kind = KIND_INCOMPLETE;
                end else begin
                    o_push             = 1'b1;
                    w_entry.first.kind = KIND_INCOMPLETE;
                end
            end
        end
    end

    assign o_entry = w_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HDR;
            r_cnt   <= 32'd0;
            r_ver   <= VERSION_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_ver <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
        r_tfmt  <= n_tfmt;
        r_opt   <= n_opt;
        r_id    <= n_id;
        r_typ   <= n_typ;
        r_dat   <= n_dat;
    end

endmodule

`default_nettype wire

[hdl/drp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module drp_queue #(
    parameter int DEPTH = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  drp_pkg::t_entry         i_entry,
    input  wire                     i_pop,
    output drp_pkg::t_entry         o_head,
    output drp_pkg::t_queue_status  o_stat
);
    import drp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[hdl/drp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module drp_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  drp_pkg::t_entry         i_head,
    input  drp_pkg::t_queue_status  i_q_stat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire                     i_ready,
    output drp_pkg::t_result        o_result
);
    import drp_pkg::*;

    logic    r_valid, n_valid;
    logic    r_pend, n_pend;
    t_kind   r_pend_kind, n_pend_kind;
    t_result r_result, n_result;
    logic    w_load;

    assign w_load = !r_valid || i_ready;

    always_comb begin
        n_valid     = r_valid;
        n_pend      = r_pend;
        n_pend_kind = r_pend_kind;
        n_result    = r_result;
        o_pop       = 1'b0;
        if (w_load) begin
            if (r_pend) begin
                // second word of the same byte carries only its kind
                n_result      = '0;
                n_result.kind = r_pend_kind;
                n_pend        = 1'b0;
                n_valid       = 1'b1;
            end else if (!i_q_stat.empty) begin
                o_pop       = 1'b1;
                n_result    = i_head.first;
                n_pend      = i_head.has_second;
                n_pend_kind = i_head.second_kind;
                n_valid     = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_kind <= n_pend_kind;
        r_result    <= n_result;
    end

endmodule

`default_nettype wire

[hdl/dime_record_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: data_byte, tlast: end_of_buffer
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: record fields, tuser: kind,
//                                                     tlast: end_of_field
// cfg       in         i_cfg_wr_en                    i_cfg_wr_data: expected_version
//
// One byte is accepted per cycle while the result queue has room; results leave at one
// word per cycle from the output register unless m_axis_tready stalls, so a byte causing
// two results (header or field byte, then record done or incomplete) holds the back end.
// Input ready depends only on queue fill, never on the output side in the same cycle.
// Reset is synchronous; no clearing pass is needed and bytes are taken right after reset.

module dime_record_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_wr_en,
    input  wire  [4:0]   i_cfg_wr_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire          s_axis_tlast,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [1:0] field_tag, [9:2] byte_value, [10] first_flag,
                                         // [11] last_flag, [12] chunked_flag,
                                         // [16:13] type_format, [32:17] options_length,
                                         // [48:33] id_length, [64:49] type_length,
                                         // [96:65] data_length, [103:97] zero
    output logic [2:0]   m_axis_tuser,   // [2:0] kind
    output logic         m_axis_tlast
);
    import drp_pkg::*;

    t_queue_status w_q_stat;
    t_entry        w_push_entry;
    t_entry        w_head;
    logic          w_push;
    logic          w_pop;
    t_result       w_result;

    drp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_data_byte     (s_axis_tdata),
        .i_end_of_buffer (s_axis_tlast),
        .i_q_stat        (w_q_stat),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    drp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    drp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {7'd0,
                           w_result.data_length,
                           w_result.type_length,
                           w_result.id_length,
                           w_result.options_length,
                           w_result.type_format,
                           w_result.chunked_flag,
                           w_result.last_flag,
                           w_result.first_flag,
                           w_result.byte_value,
                           w_result.field_tag};
    assign m_axis_tuser = w_result.kind;
    assign m_axis_tlast = w_result.end_of_field;

endmodule

`default_nettype wire
